/* rtl/core/adbd_pkg.sv */
`timescale 1ns / 1ps
// Shared constants of the anchor distance box decoder: register map, field widths, defaults.
package adbd_pkg;

	// Default sizing of the decoder
	localparam int unsigned ANCHORS_PER_CELL_DEF = 2;
	localparam int unsigned MAX_NET_DIM_DEF      = 2048;
	localparam int unsigned NUM_LEVELS_DEF       = 3;

	// Configuration port
	localparam int unsigned CFG_ADDR_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_SCORE_THRESHOLD = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_NET_WIDTH       = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_NET_HEIGHT      = 2'd2;

	// Register widths and reset values
	localparam int unsigned THRESHOLD_W = 16;
	localparam int unsigned SIZE_REG_W  = 12;

	localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST  = 16'd32768;
	localparam logic [SIZE_REG_W-1:0]  NET_WIDTH_RST  = 12'd640;
	localparam logic [SIZE_REG_W-1:0]  NET_HEIGHT_RST = 12'd640;

	// Item fields
	localparam int unsigned SCORE_W     = 16;
	localparam int unsigned DIST_W      = 16;
	localparam int unsigned COORD_W     = 15;
	localparam int unsigned LEVEL_OUT_W = 2;

	localparam int unsigned IN_TDATA_W  = 80;
	localparam int unsigned OUT_FIELD_W = 4 * COORD_W + SCORE_W;
	localparam int unsigned OUT_TDATA_W = 80;

	// Fixed point: distances and positions in Q.10, boxes in Q.4
	localparam int unsigned Q10_FRAC     = 10;
	localparam int unsigned ROUND_SHIFT  = 6;
	localparam int unsigned ROUND_HALF   = 32;
	localparam int unsigned BASE_SHIFT   = 3;
	localparam logic [COORD_W-1:0] COORD_MAX = 15'h7FFF;

endpackage

/* rtl/core/anchor_distance_box_decoder.sv */
`timescale 1ns / 1ps
// Anchor distance box decoder: scan tracking, box decode, clamp and output stage.

// Takes one anchor prediction per item and tracks the scan position (level with stride
// 8 << level, row, column, anchor) itself; an item with frame_start set restarts the scan.
// A prediction whose score reaches score_threshold becomes a box in Q11.4 pixels, clamped
// to the network size and sent only if its width and height are nonzero. One item is
// accepted every cycle while the result side takes its results; a result leaves through
// an input stage that holds the settled scan position and a result register. Back-pressure
// on the result side holds the result register; the input stage still takes one more item
// while it is empty, and after that the input stalls. Write configuration only while no
// item is in flight.
module anchor_distance_box_decoder #(
	parameter int unsigned ANCHORS_PER_CELL = adbd_pkg::ANCHORS_PER_CELL_DEF,
	parameter int unsigned MAX_NET_DIM      = adbd_pkg::MAX_NET_DIM_DEF,
	parameter int unsigned NUM_LEVELS       = adbd_pkg::NUM_LEVELS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration
	input  logic                                   cfg_we,
	input  logic [adbd_pkg::CFG_ADDR_W-1:0]        cfg_addr,
	input  logic [adbd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	// prediction items
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// score[15:0], dist_left[31:16], dist_top[47:32], dist_right[63:48], dist_bottom[79:64]
	input  logic [adbd_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
	// frame_start[0]
	input  logic                                   s_axis_tuser,
	// box items
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// box_left[14:0], box_top[29:15], box_width[44:30], box_height[59:45],
	// confidence[75:60], zero fill[79:76]
	output logic [adbd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	// scale_level[1:0]
	output logic [adbd_pkg::LEVEL_OUT_W-1:0]       m_axis_tuser
);

	localparam int unsigned LW   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int unsigned AW   = $clog2(ANCHORS_PER_CELL + 1);
	localparam int unsigned SZW  = $clog2(MAX_NET_DIM + 1);
	localparam int unsigned GMAX = MAX_NET_DIM >> adbd_pkg::BASE_SHIFT;
	localparam int unsigned CW   = $clog2(GMAX + 1);
	localparam int unsigned SHW  = $clog2(NUM_LEVELS + adbd_pkg::BASE_SHIFT);
	// position minus distance, before the stride shift
	localparam int unsigned DW   = ((CW + adbd_pkg::Q10_FRAC + 1 > adbd_pkg::DIST_W) ?
		CW + adbd_pkg::Q10_FRAC + 1 : adbd_pkg::DIST_W) + 1;
	localparam int unsigned PW   = DW + NUM_LEVELS + adbd_pkg::BASE_SHIFT - 1;
	localparam int unsigned CLW  = SZW + adbd_pkg::Q10_FRAC;
	localparam int unsigned MW   = (PW > CLW) ? PW : CLW;
	localparam int unsigned RW   = CLW + 1 - adbd_pkg::ROUND_SHIFT;

	localparam int unsigned CW_ = adbd_pkg::COORD_W;

	// configuration registers
	logic [adbd_pkg::THRESHOLD_W-1:0] threshold_q;
	logic [adbd_pkg::SIZE_REG_W-1:0]  net_width_q;
	logic [adbd_pkg::SIZE_REG_W-1:0]  net_height_q;

	// scan position
	logic [LW-1:0] level_q;
	logic [CW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [AW-1:0] anchor_q;

	// input stage
	logic                                  valid_s1;
	logic                                  ok_s1;
	logic [adbd_pkg::SCORE_W-1:0]          score_s1;
	logic signed [adbd_pkg::DIST_W-1:0]    dl_s1, dt_s1, dr_s1, db_s1;
	logic [LW-1:0]                         level_s1;
	logic [CW-1:0]                         row_s1;
	logic [CW-1:0]                         col_s1;

	// result register
	logic                                  out_valid_q;
	logic [CW_-1:0]                        box_left_q, box_top_q, box_width_q, box_height_q;
	logic [adbd_pkg::SCORE_W-1:0]          confidence_q;
	logic [LW-1:0]                         level_q2;

	logic in_acc;
	logic out_load;

	logic [SZW-1:0] eff_w, eff_h;
	logic [CW-1:0]  grid_w [NUM_LEVELS];
	logic [CW-1:0]  grid_h [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] level_used;

	logic [LW-1:0] cur_level;
	logic [CW-1:0] cur_row, cur_col;
	logic [AW-1:0] cur_anchor;
	logic [LW-1:0] set_level;
	logic [CW-1:0] set_row, set_col;
	logic [AW-1:0] set_anchor;
	logic          set_ok;

	function automatic logic [CW_-1:0] to_coord(input logic signed [PW-1:0] q,
		input logic [CLW-1:0] hi);
		logic [MW-1:0]  qu;
		logic [CLW-1:0] c;
		logic [CLW:0]   rnd;
		logic [RW-1:0]  r;
		qu = MW'(q);
		if (q < 0) begin
			c = '0;
		end else if (qu > MW'(hi)) begin
			c = hi;
		end else begin
			c = CLW'(qu);
		end
		rnd = {1'b0, c} + (CLW + 1)'(adbd_pkg::ROUND_HALF);
		r = RW'(rnd >> adbd_pkg::ROUND_SHIFT);
		return (32'(r) > 32'(adbd_pkg::COORD_MAX)) ? adbd_pkg::COORD_MAX : CW_'(r);
	endfunction

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_load      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || out_load;

	// sizes above the supported maximum act as the maximum
	assign eff_w = (13'(net_width_q) > 13'(MAX_NET_DIM)) ? SZW'(MAX_NET_DIM) : SZW'(net_width_q);
	assign eff_h = (13'(net_height_q) > 13'(MAX_NET_DIM)) ? SZW'(MAX_NET_DIM) :
		SZW'(net_height_q);

	always_comb begin
		for (int l = 0; l < NUM_LEVELS; l++) begin
			grid_w[l]     = CW'(eff_w >> (l + adbd_pkg::BASE_SHIFT));
			grid_h[l]     = CW'(eff_h >> (l + adbd_pkg::BASE_SHIFT));
			level_used[l] = (grid_w[l] != '0) && (grid_h[l] != '0);
		end
	end

	// Settle the scan position for the incoming item: step past a finished cell or line,
	// else move to the next level that has cells, wrapping after the last one.
	always_comb begin
		logic [AW-1:0] a1;
		logic [CW-1:0] c1, r1;
		logic          here_ok;
		logic          found;
		logic [LW-1:0] next_level;
		cur_level  = s_axis_tuser ? '0 : level_q;
		cur_row    = s_axis_tuser ? '0 : row_q;
		cur_col    = s_axis_tuser ? '0 : col_q;
		cur_anchor = s_axis_tuser ? '0 : anchor_q;
		a1 = cur_anchor;
		c1 = cur_col;
		r1 = cur_row;
		if (cur_anchor >= AW'(ANCHORS_PER_CELL)) begin
			a1 = '0;
			c1 = cur_col + 1'b1;
		end
		if (c1 >= grid_w[cur_level]) begin
			c1 = '0;
			a1 = '0;
			r1 = cur_row + 1'b1;
		end
		here_ok = (r1 < grid_h[cur_level]) && (grid_w[cur_level] != '0);
		found      = 1'b0;
		next_level = '0;
		for (int k = 1; k <= NUM_LEVELS; k++) begin
			int idx;
			idx = int'(cur_level) + k;
			if (idx >= NUM_LEVELS) begin
				idx = idx - NUM_LEVELS;
			end
			if (!found && level_used[idx]) begin
				found      = 1'b1;
				next_level = LW'(idx);
			end
		end
		if (here_ok) begin
			set_ok     = 1'b1;
			set_level  = cur_level;
			set_row    = r1;
			set_col    = c1;
			set_anchor = a1;
		end else begin
			set_ok     = found;
			set_level  = next_level;
			set_row    = '0;
			set_col    = '0;
			set_anchor = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= adbd_pkg::THRESHOLD_RST;
			net_width_q  <= adbd_pkg::NET_WIDTH_RST;
			net_height_q <= adbd_pkg::NET_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				adbd_pkg::REG_SCORE_THRESHOLD: threshold_q <= cfg_wdata;
				adbd_pkg::REG_NET_WIDTH: net_width_q <= cfg_wdata[adbd_pkg::SIZE_REG_W-1:0];
				adbd_pkg::REG_NET_HEIGHT: net_height_q <= cfg_wdata[adbd_pkg::SIZE_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the scan on every accepted item; with no cell anywhere, park it at home
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			row_q    <= '0;
			col_q    <= '0;
			anchor_q <= '0;
		end else if (in_acc) begin
			if (set_ok) begin
				level_q  <= set_level;
				row_q    <= set_row;
				col_q    <= set_col;
				anchor_q <= set_anchor + 1'b1;
			end else begin
				level_q  <= '0;
				row_q    <= '0;
				col_q    <= '0;
				anchor_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ok_s1    <= set_ok;
			score_s1 <= s_axis_tdata[15:0];
			dl_s1    <= s_axis_tdata[31:16];
			dt_s1    <= s_axis_tdata[47:32];
			dr_s1    <= s_axis_tdata[63:48];
			db_s1    <= s_axis_tdata[79:64];
			level_s1 <= set_level;
			row_s1   <= set_row;
			col_s1   <= set_col;
		end
	end

	// box decode from the input stage
	logic [SHW-1:0]       sh;
	logic signed [DW-1:0] pos_x, pos_y;
	logic signed [PW-1:0] dx1, dy1, dx2, dy2;
	logic [CLW-1:0]       hi_w, hi_h;
	logic [CW_-1:0]       x1, y1, x2, y2;
	logic                 hit;

	always_comb begin
		sh    = SHW'(level_s1) + SHW'(adbd_pkg::BASE_SHIFT);
		pos_x = DW'($signed({1'b0, col_s1, {adbd_pkg::Q10_FRAC{1'b0}}}));
		pos_y = DW'($signed({1'b0, row_s1, {adbd_pkg::Q10_FRAC{1'b0}}}));
		dx1   = PW'(pos_x - DW'(dl_s1));
		dy1   = PW'(pos_y - DW'(dt_s1));
		dx2   = PW'(pos_x + DW'(dr_s1));
		dy2   = PW'(pos_y + DW'(db_s1));
		hi_w  = {SZW'(eff_w - 1'b1), {adbd_pkg::Q10_FRAC{1'b0}}};
		hi_h  = {SZW'(eff_h - 1'b1), {adbd_pkg::Q10_FRAC{1'b0}}};
		x1    = to_coord(dx1 <<< sh, hi_w);
		y1    = to_coord(dy1 <<< sh, hi_h);
		x2    = to_coord(dx2 <<< sh, hi_w);
		y2    = to_coord(dy2 <<< sh, hi_h);
		hit   = ok_s1 && (score_s1 >= threshold_q) && (x2 > x1) && (y2 > y1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			box_left_q   <= x1;
			box_top_q    <= y1;
			box_width_q  <= x2 - x1;
			box_height_q <= y2 - y1;
			confidence_q <= score_s1;
			level_q2     <= level_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(adbd_pkg::OUT_TDATA_W - adbd_pkg::OUT_FIELD_W){1'b0}},
		confidence_q, box_height_q, box_width_q, box_top_q, box_left_q};
	assign m_axis_tuser  = adbd_pkg::LEVEL_OUT_W'(level_q2);

	a_box_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (box_width_q != '0) && (box_height_q != '0))
		else $error("box sent with zero width or height");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(level_q) < NUM_LEVELS)
		else $error("scan level out of range");

	a_anchor_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(anchor_q) <= ANCHORS_PER_CELL)
		else $error("anchor index beyond cell");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_axis_tuser && level_used[0] |=>
		ok_s1 && (level_s1 == '0) && (row_s1 == '0) && (col_s1 == '0))
		else $error("frame start did not restart the scan");

	a_out_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> 32'(level_q2) < NUM_LEVELS)
		else $error("result carries an unknown level");

endmodule
